// File: sv/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, request types and codes for the clipped 11x11 box mean
// filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // window geometry
    localparam int RADIUS     = 5;
    localparam int WIN_SIZE   = 2 * RADIUS + 1;
    localparam int MAX_COUNT  = WIN_SIZE * WIN_SIZE;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // field and counter widths
    localparam int PIX_W    = 16;
    localparam int DIM_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int OROW_W   = $clog2(MAX_HEIGHT);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2 * WIN_SIZE);
    localparam int CS_W     = 20;
    localparam int WS_W     = 23;
    localparam int CNT_W    = $clog2(MAX_COUNT + 1);
    localparam int SPAN_W   = $clog2(WIN_SIZE + 1);
    localparam int DIFF_W   = 15;
    localparam int J_W      = $clog2(RADIUS + 1);

    // line store: one row slot per window row
    localparam int SLOT_W     = $clog2(WIN_SIZE);
    localparam int LINE_DEPTH = WIN_SIZE * MAX_WIDTH;
    localparam int LINE_AW    = SLOT_W + COL_W;

    // column sums: banks hold successive row versions
    localparam int BANK_W   = 3;
    localparam int CS_DEPTH = (1 << BANK_W) * MAX_WIDTH;
    localparam int CS_AW    = BANK_W + COL_W;

    // divider: quotient bits produced one per cycle
    localparam int QUO_W  = PIX_W;
    localparam int STEP_W = $clog2(QUO_W);

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel_value;
    } bmf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             frame_last;
    } bmf_out_t;

    typedef struct packed {
        logic             valid;
        logic [WS_W-1:0]  numer;
        logic [CNT_W-1:0] denom;
        logic             last;
    } bmf_div_req_t;

endpackage

// File: sv/bmf_window.sv
// ----------------------------------------------------------------------------
// bmf_window
// Request sequencer with line store and banked column sums. Each step writes
// one pixel in the pixel phase, updates one column sum, and each result
// slides the window sum across the row before handing it to the divider.
// ----------------------------------------------------------------------------
module bmf_window
    import bmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic [DIM_W-1:0]   img_w,
    input  logic [DIM_W-1:0]   img_h,
    input  logic               src_valid,
    output logic               src_stall,
    input  bmf_in_t            src_data,
    output bmf_div_req_t       div_req,
    input  logic               div_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_CHK,
        S_WRD,
        S_WACC,
        S_DIV
    } state_t;

    state_t              state_reg,  state_next;
    logic                drain_reg,  drain_next;
    logic [PIX_W-1:0]    pix_reg,    pix_next;
    logic [ROW_W-1:0]    ri_reg,     ri_next;
    logic [COL_W-1:0]    ci_reg,     ci_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [OROW_W-1:0]   ro_reg,     ro_next;
    logic [COL_W-1:0]    co_reg,     co_next;
    logic [DIFF_W-1:0]   diff_reg,   diff_next;
    logic [WS_W-1:0]     ws_reg,     ws_next;
    logic [J_W-1:0]      j_reg,      j_next;

    // memories and their read registers
    logic [PIX_W-1:0]    line_mem [LINE_DEPTH];
    logic [CS_W-1:0]     cs_mem   [CS_DEPTH];
    logic [PIX_W-1:0]    line_rd_reg;
    logic [CS_W-1:0]     cs_rd_reg;

    logic [LINE_AW-1:0]  line_addr;
    logic                line_we, line_re;
    logic [CS_AW-1:0]    cs_raddr, cs_waddr;
    logic                cs_we, cs_re;
    logic [CS_W-1:0]     cs_wdata;

    logic [COL_W-1:0]    w_m1;
    logic [DIM_W-1:0]    h_m1;
    logic                pix_phase;
    logic [DIFF_W-1:0]   lag;
    logic                out_due;
    logic [BANK_W-1:0]   upd_bank, old_bank;
    logic                row_start;
    logic [J_W-1:0]      j_last;
    logic [DIM_W-1:0]    add_col;
    logic                add_ok, sub_ok;
    logic [COL_W-1:0]    sub_col, win_col;
    logic [CS_W-1:0]     old_term, new_term, drop_term;
    logic [DIM_W-1:0]    ro_x, r_lo, r_hi_raw, r_hi, r_span;
    logic [DIM_W-1:0]    co_x, c_lo, c_hi_raw, c_hi, c_span;
    logic [SPAN_W-1:0]   n_rows, n_cols;
    logic [CNT_W-1:0]    count;
    logic                frame_end;
    logic                ci_wrap;

    // frame geometry
    assign w_m1      = COL_W'(img_w - DIM_W'(1));
    assign h_m1      = img_h - DIM_W'(1);
    assign pix_phase = ri_reg < ROW_W'(img_h);
    assign lag       = DIFF_W'(img_w) * DIFF_W'(RADIUS) + DIFF_W'(RADIUS);
    assign out_due   = diff_reg > lag;
    assign ci_wrap   = ci_reg == w_m1;

    // column sum row version v lives in bank v mod 8
    assign upd_bank = BANK_W'(ri_reg - ROW_W'(RADIUS));
    assign old_bank = upd_bank - BANK_W'(1);

    // window column selection
    assign row_start = co_reg == '0;
    assign j_last    = (w_m1 < COL_W'(RADIUS)) ? J_W'(w_m1) : J_W'(RADIUS);
    assign add_col   = DIM_W'(co_reg) + DIM_W'(RADIUS);
    assign add_ok    = add_col <= DIM_W'(w_m1);
    assign sub_ok    = co_reg >= COL_W'(RADIUS + 1);
    assign sub_col   = co_reg - COL_W'(RADIUS + 1);
    assign win_col   = row_start ? COL_W'(j_reg)
                     : ((j_reg == '0) ? COL_W'(add_col) : sub_col);

    // column sum update terms, rows outside the frame count as zero
    assign old_term  = (ri_reg == '0) ? '0 : cs_rd_reg;
    assign new_term  = pix_phase ? CS_W'(pix_reg) : '0;
    assign drop_term = (ri_reg >= ROW_W'(WIN_SIZE)) ? CS_W'(line_rd_reg) : '0;
    assign cs_wdata  = old_term + new_term - drop_term;

    // clipped window size
    assign ro_x     = DIM_W'(ro_reg);
    assign r_lo     = (ro_x >= DIM_W'(RADIUS)) ? ro_x - DIM_W'(RADIUS) : '0;
    assign r_hi_raw = ro_x + DIM_W'(RADIUS);
    assign r_hi     = (r_hi_raw > h_m1) ? h_m1 : r_hi_raw;
    assign r_span   = r_hi - r_lo + DIM_W'(1);
    assign co_x     = DIM_W'(co_reg);
    assign c_lo     = (co_x >= DIM_W'(RADIUS)) ? co_x - DIM_W'(RADIUS) : '0;
    assign c_hi_raw = co_x + DIM_W'(RADIUS);
    assign c_hi     = (c_hi_raw > DIM_W'(w_m1)) ? DIM_W'(w_m1) : c_hi_raw;
    assign c_span   = c_hi - c_lo + DIM_W'(1);
    assign n_rows   = SPAN_W'(r_span);
    assign n_cols   = SPAN_W'(c_span);
    assign count    = CNT_W'(n_rows) * CNT_W'(n_cols);
    assign frame_end = (ro_x == h_m1) && (co_reg == w_m1);

    // memory port control
    assign line_addr = {slot_reg, ci_reg};
    assign line_re   = state_reg == S_RD;
    assign line_we   = (state_reg == S_UPD) && pix_phase;
    assign cs_re     = (state_reg == S_RD) || (state_reg == S_WRD);
    assign cs_raddr  = (state_reg == S_RD) ? {old_bank, ci_reg}
                                           : {ro_reg[BANK_W-1:0], win_col};
    assign cs_we     = state_reg == S_UPD;
    assign cs_waddr  = {upd_bank, ci_reg};

    // handshakes
    assign src_stall     = state_reg != S_IDLE;
    assign div_req.valid = state_reg == S_DIV;
    assign div_req.numer = ws_reg + WS_W'(count >> 1);
    assign div_req.denom = count;
    assign div_req.last  = frame_end;

    // line store
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_addr] <= pix_reg;
        end
        if (line_re)
        begin
            line_rd_reg <= line_mem[line_addr];
        end
    end

    // column sum store
    always_ff @(posedge clk)
    begin
        if (cs_we)
        begin
            cs_mem[cs_waddr] <= cs_wdata;
        end
        if (cs_re)
        begin
            cs_rd_reg <= cs_mem[cs_raddr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        pix_next   = pix_reg;
        ri_next    = ri_reg;
        ci_next    = ci_reg;
        slot_next  = slot_reg;
        ro_next    = ro_reg;
        co_next    = co_reg;
        diff_next  = diff_reg;
        ws_next    = ws_reg;
        j_next     = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                // drain request during the pixel phase is dropped
                if (src_valid && !(pix_phase && src_data.cmd == CMD_DRAIN))
                begin
                    pix_next   = src_data.pixel_value;
                    drain_next = !pix_phase;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // advance the input position
                diff_next = diff_reg + DIFF_W'(1);
                if (ci_wrap)
                begin
                    ci_next   = '0;
                    ri_next   = ri_reg + ROW_W'(1);
                    slot_next = (slot_reg == SLOT_W'(WIN_SIZE - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);
                end
                else
                begin
                    ci_next = ci_reg + COL_W'(1);
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (out_due)
                begin
                    j_next     = '0;
                    state_next = S_WRD;
                end
                else if (drain_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRD:
            begin
                state_next = S_WACC;
            end
            S_WACC:
            begin
                // row start sums the first columns, otherwise slide by one
                if (row_start)
                begin
                    ws_next = ((j_reg == '0) ? '0 : ws_reg) + WS_W'(cs_rd_reg);
                end
                else if (j_reg == '0)
                begin
                    ws_next = ws_reg + (add_ok ? WS_W'(cs_rd_reg) : '0);
                end
                else
                begin
                    ws_next = ws_reg - (sub_ok ? WS_W'(cs_rd_reg) : '0);
                end
                if ((row_start && j_reg == j_last) || (!row_start && j_reg != '0))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    j_next     = j_reg + J_W'(1);
                    state_next = S_WRD;
                end
            end
            S_DIV:
            begin
                if (div_ready)
                begin
                    diff_next = diff_reg - DIFF_W'(1);
                    if (co_reg == w_m1)
                    begin
                        co_next = '0;
                        ro_next = ro_reg + OROW_W'(1);
                    end
                    else
                    begin
                        co_next = co_reg + COL_W'(1);
                    end
                    if (frame_end)
                    begin
                        ri_next   = '0;
                        ci_next   = '0;
                        slot_next = '0;
                        ro_next   = '0;
                        co_next   = '0;
                        diff_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // register write abandons the frame
        if (restart)
        begin
            ri_next   = '0;
            ci_next   = '0;
            slot_next = '0;
            ro_next   = '0;
            co_next   = '0;
            diff_next = '0;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
            ri_reg    <= '0;
            ci_reg    <= '0;
            slot_reg  <= '0;
            ro_reg    <= '0;
            co_reg    <= '0;
            diff_reg  <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            ri_reg    <= ri_next;
            ci_reg    <= ci_next;
            slot_reg  <= slot_next;
            ro_reg    <= ro_next;
            co_reg    <= co_next;
            diff_reg  <= diff_next;
            j_reg     <= j_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        ws_reg  <= ws_next;
    end

endmodule

// File: sv/bmf_div.sv
// ----------------------------------------------------------------------------
// bmf_div
// Radix-2 restoring divider for the window mean, one quotient bit per cycle,
// followed by the output register.
// ----------------------------------------------------------------------------
module bmf_div
    import bmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bmf_div_req_t  div_req,
    output logic          div_ready,
    output logic          dst_valid,
    input  logic          dst_stall,
    output bmf_out_t      dst_data
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_DONE
    } dstate_t;

    localparam int REM_W = WS_W - QUO_W;

    dstate_t             dstate_reg, dstate_next;
    logic [STEP_W-1:0]   step_reg,   step_next;
    logic                out_valid_reg, out_valid_next;
    logic [REM_W-1:0]    rem_reg,    rem_next;
    logic [QUO_W-1:0]    quo_reg,    quo_next;
    logic [CNT_W-1:0]    den_reg,    den_next;
    logic                last_reg,   last_next;
    bmf_out_t            out_reg,    out_next;

    logic [REM_W:0]      trial;
    logic                ge;
    logic [REM_W:0]      diff_val;
    logic                load_out;

    // one restoring step
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign ge       = trial >= (REM_W + 1)'(den_reg);
    assign diff_val = trial - (REM_W + 1)'(den_reg);
    assign load_out = (dstate_reg == D_DONE) && (!out_valid_reg || !dst_stall);

    assign div_ready = dstate_reg == D_IDLE;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    always_comb
    begin
        dstate_next    = dstate_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (dstate_reg)
            D_IDLE:
            begin
                // quotient fits in 16 bits, so the top bits start as remainder
                if (div_req.valid)
                begin
                    rem_next    = div_req.numer[WS_W-1:QUO_W];
                    quo_next    = div_req.numer[QUO_W-1:0];
                    den_next    = div_req.denom;
                    last_next   = div_req.last;
                    step_next   = '0;
                    dstate_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next  = ge ? REM_W'(diff_val) : REM_W'(trial);
                quo_next  = {quo_reg[QUO_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    dstate_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (load_out)
                begin
                    out_next.filtered_pixel = quo_reg;
                    out_next.frame_last     = last_reg;
                    out_valid_next          = 1'b1;
                    dstate_next             = D_IDLE;
                end
            end
            default:
            begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    // control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg    <= D_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dstate_reg    <= dstate_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

endmodule

// File: sv/box_mean_filter_11x11.sv
// ----------------------------------------------------------------------------
// box_mean_filter_11x11
// Streaming clipped 11x11 box mean over one frame of 16-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   src channel takes pixel requests in raster order (cmd pixel), then drain
//   requests after the frame; dst channel returns the rounded window mean.
//   Result k leaves on input request k + 5*width + 5; drain requests push out
//   the rest, and frame_last marks the final result, after which a new frame
//   starts. Drain requests during the pixel phase are dropped.
//   An input request without a result passes the sequencer's read, update
//   and check steps; one with a result then reads and adds column sums, up
//   to six in the first column of a row, else one added and one taken off.
//   The divider finds 16 quotient bits per result and takes no new request
//   until the last result has moved into the output register.
//   For a frame of no more than 5*width+5 pixels the first drain request
//   walks the remaining positions (read, update, check) before its result.
//   Reset clears all counters and sets width and height to 4096; the memories
//   need no clearing pass. A register write restarts the frame.
//   A stalled result holds in the output register; the sequencer waits for
//   the divider and stops taking requests until it can continue.
// ----------------------------------------------------------------------------
module box_mean_filter_11x11
    import bmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  bmf_in_t               src_data,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output bmf_out_t              dst_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [DIM_W-1:0] width_reg,  width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] eff_w, eff_h;
    bmf_div_req_t     div_req;
    logic             div_ready;

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_next  = DIM_W'(cfg_data);
                CFG_IMAGE_HEIGHT: height_next = DIM_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // zero acts as one, oversize acts as the maximum
    assign eff_w = (width_reg == '0) ? DIM_W'(1)
                 : ((width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg);
    assign eff_h = (height_reg == '0) ? DIM_W'(1)
                 : ((height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg);

    bmf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_write),
        .img_w     (eff_w),
        .img_h     (eff_h),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .div_req   (div_req),
        .div_ready (div_ready)
    );

    bmf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .div_req   (div_req),
        .div_ready (div_ready),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // divider goes busy once it takes a request
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.valid && div_ready |=> !div_ready)
        else $error("divider did not take the request");

    // clipped window holds between 1 and 121 pixels
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.valid |-> (div_req.denom != '0) && (div_req.denom <= CNT_W'(MAX_COUNT)))
        else $error("window count out of range");

    // a new result only comes from a finished division
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(!div_ready))
        else $error("result loaded without a division");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped 11x11 box mean filter. Frames of random
// size and content are streamed in raster order with drain requests after
// them; an in-bench window-mean predictor supplies the expected results and a
// scoreboard compares them in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    import bmf_pkg::*;

    localparam int RING_LEN   = 2 * (RADIUS * MAX_WIDTH + RADIUS) + 1;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE     = 60;

    // predictor of the filter plus the queue of expected means
    class window_mean_board;
        logic [PIX_W-1:0] ring [RING_LEN];
        int unsigned      width_reg;
        int unsigned      height_reg;
        int unsigned      pos_count;
        int unsigned      emitted;
        bmf_out_t         pending_means [$];
        int               errors;

        function new();
            width_reg  = MAX_WIDTH;
            height_reg = MAX_HEIGHT;
            pos_count  = 0;
            emitted    = 0;
            errors     = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned mx);
            if (v < 1) return 1;
            if (v > mx) return mx;
            return v;
        endfunction

        function int unsigned eff_w();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned eff_h();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        // register write restarts the frame
        function void set_register(cfg_index_t idx, int unsigned v);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = v & 16'h1FFF;
            else
                height_reg = v & 16'h1FFF;
            pos_count = 0;
            emitted   = 0;
        endfunction

        function logic [PIX_W-1:0] window_mean(int unsigned k, int unsigned w,
                                               int unsigned h);
            int unsigned r, c, r0, r1, c0, c1, sum, count;
            r  = k / w;
            c  = k % w;
            r0 = (r >= RADIUS) ? r - RADIUS : 0;
            c0 = (c >= RADIUS) ? c - RADIUS : 0;
            r1 = (r + RADIUS > h - 1) ? h - 1 : r + RADIUS;
            c1 = (c + RADIUS > w - 1) ? w - 1 : c + RADIUS;
            count = (r1 - r0 + 1) * (c1 - c0 + 1);
            sum = 0;
            for (int unsigned rr = r0; rr <= r1; rr++)
                for (int unsigned cc = c0; cc <= c1; cc++)
                    sum += ring[(rr * w + cc) % RING_LEN];
            return PIX_W'((sum + count / 2) / count);
        endfunction

        function void note_request(bmf_in_t req);
            int unsigned w, h, total, lag;
            bmf_out_t    res;
            w = eff_w();
            h = eff_h();
            total = w * h;
            lag = RADIUS * w + RADIUS;
            if (pos_count < total) begin
                // pixel phase: drains are dropped
                if (req.cmd == CMD_DRAIN)
                    return;
                ring[pos_count % RING_LEN] = req.pixel_value;
                pos_count++;
                if (pos_count - 1 >= lag) begin
                    res.filtered_pixel = window_mean(emitted, w, h);
                    res.frame_last = 1'b0;
                    emitted++;
                    pending_means.push_back(res);
                end
                return;
            end
            // drain phase: any request pushes one result
            res.filtered_pixel = window_mean(emitted, w, h);
            res.frame_last = 1'b0;
            emitted++;
            if (emitted >= total) begin
                res.frame_last = 1'b1;
                pos_count = 0;
                emitted = 0;
            end
            pending_means.push_back(res);
        endfunction

        function void check_result(bmf_out_t got);
            bmf_out_t exp_res;
            if (pending_means.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h/%b", $time,
                         got.filtered_pixel, got.frame_last);
                return;
            end
            exp_res = pending_means.pop_front();
            if (got.filtered_pixel !== exp_res.filtered_pixel) begin
                errors++;
                $display("%0t: filtered_pixel expected %h actual %h", $time,
                         exp_res.filtered_pixel, got.filtered_pixel);
            end
            if (got.frame_last !== exp_res.frame_last) begin
                errors++;
                $display("%0t: frame_last expected %b actual %b", $time,
                         exp_res.frame_last, got.frame_last);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 src_valid;
    logic                 src_stall;
    bmf_in_t              src_data;
    logic                 dst_valid;
    logic                 dst_stall;
    bmf_out_t             dst_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    window_mean_board board;
    bit               quiet;
    int               sent_items;
    int               idle_cycles;
    int               stall_left;

    box_mean_filter_11x11 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #6 clk = ~clk;

    // random gap length, mostly short, a few long
    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return PIX_W'($urandom_range(0, 65535));
    endfunction

    // drive one request and wait for it to be taken
    task automatic send_request(logic cmd, logic [PIX_W-1:0] pix);
        int gap;
        bmf_in_t req;
        gap = pick_gap();
        req.cmd = cmd;
        req.pixel_value = pix;
        if (gap > 0)
        begin
            @(negedge clk) src_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        src_valid <= 1'b1;
        src_data  <= req;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        board.note_request(req);
        sent_items++;
    endtask

    // hold off until every expected result has come
    task automatic wait_drained();
        @(negedge clk) src_valid <= 1'b0;
        while (board.pending_means.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, int unsigned v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(v);
        board.set_register(idx, v);
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
    endtask

    // pixels of one frame, then drains until frame_last; partial > 0 stops early
    task automatic run_frame(int unsigned partial);
        int unsigned n;
        n = (partial != 0) ? partial : board.eff_w() * board.eff_h();
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(CMD_DRAIN, pick_pixel());
            send_request(CMD_PIXEL, pick_pixel());
        end
        if (partial != 0)
            return;
        while (board.pos_count != 0)
            send_request(logic'($urandom_range(0, 1)), pick_pixel());
    endtask

    // result side: random stall and in-order check
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                dst_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 9) < 3)
            begin
                dst_stall <= 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ?
                             $urandom_range(10, 40) : $urandom_range(0, 2);
            end
            else
                dst_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            board.check_result(dst_data);
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int unsigned total;
        bit          mid_frame;
        board       = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        dst_stall   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        quiet       = 1'b0;
        sent_items  = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset geometry: a few pixels give nothing, then abandon the frame
        run_frame(3);
        // small frame of full-scale pixels, drains mixed in
        set_size(3, 2);
        for (int i = 0; i < 6; i++)
        begin
            if (i == 2)
                send_request(CMD_DRAIN, '0);
            send_request(CMD_PIXEL, '1);
        end
        send_request(CMD_PIXEL, 16'h1234);
        wait_drained();
        while (board.pos_count != 0)
            send_request(CMD_DRAIN, '0);
        // zero registers act as one: single pixel frame
        set_size(0, 0);
        send_request(CMD_PIXEL, 16'hABCD);
        send_request(CMD_PIXEL, '0);
        // width above range clamps: a short partial frame gives nothing
        set_size(8191, 1);
        run_frame(12);
        // height above range clamps: one column, partial frame
        set_size(1, 8191);
        run_frame(40);

        // random frames, mostly small
        mid_frame = 1'b1;
        while (sent_items < 1800)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if (mid_frame || $urandom_range(0, 2) != 0)
            begin
                write_register(CFG_IMAGE_WIDTH, ($urandom_range(0, 19) == 0) ?
                               0 : $urandom_range(1, 12));
                write_register(CFG_IMAGE_HEIGHT, $urandom_range(0, 12));
            end
            total = board.eff_w() * board.eff_h();
            mid_frame = (total > 1 && $urandom_range(0, 5) == 0);
            if (mid_frame)
                run_frame($urandom_range(1, total - 1));
            else
                run_frame(0);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.pending_means.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: box_mean_filter_11x11.f
sv/bmf_pkg.sv
sv/bmf_window.sv
sv/bmf_div.sv
sv/box_mean_filter_11x11.sv
tb/sv/tb.sv
